// ===== rtl/mwc_pkg.sv =====
// Shared codes and types for the maze wall carver.
package mwc_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_CARVE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StBorder = 2'd1,
    StJoined = 2'd2,
    StBad    = 2'd3
  } status_e;

  // Decoded view of one input beat
  typedef struct packed {
    logic is_clear;  // clear whole maze
    logic is_carve;  // carve, else query
    logic bad;       // bad opcode, coordinates or carve direction
    logic border;    // carve through the grid border
    logic closed;    // query through the grid border
    logic dir_up;    // target is an up bit, else a right bit
  } dec_t;

endpackage

// ===== rtl/mwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mwc_ram #(
  parameter int Width = 12,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mwc_decode.sv =====
// Input beat decode: grid size clamping, range checks and cell addresses.
module mwc_decode #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32,
  localparam int CellCount = MAX_WIDTH * MAX_HEIGHT,
  localparam int IdxW      = $clog2(CellCount)
) (
  input  logic [1:0]      opcode_i,
  input  logic [4:0]      cell_x_i,
  input  logic [4:0]      cell_y_i,
  input  logic [1:0]      direction_i,
  input  logic [5:0]      grid_width_i,
  input  logic [5:0]      grid_height_i,
  output mwc_pkg::dec_t   dec_o,
  output logic [IdxW-1:0] rd_addr_o,
  output logic [IdxW-1:0] nb_addr_o
);

  import mwc_pkg::*;

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);
  localparam logic [6:0] MaxH = 7'(MAX_HEIGHT);

  logic [6:0] wu, hu, w, h, x7, y7;
  logic       outside;

  function automatic logic [IdxW-1:0] cell_idx(input int col, input int row);
    return IdxW'(row * MAX_WIDTH + col);
  endfunction

  // Clamp grid size to [2, max]
  assign wu = {1'b0, grid_width_i};
  assign hu = {1'b0, grid_height_i};
  assign w  = (wu < 7'd2) ? 7'd2 : ((wu > MaxW) ? MaxW : wu);
  assign h  = (hu < 7'd2) ? 7'd2 : ((hu > MaxH) ? MaxH : hu);
  assign x7 = {2'b00, cell_x_i};
  assign y7 = {2'b00, cell_y_i};
  assign outside = (x7 >= w) || (y7 >= h);

  // Classification
  always_comb begin
    dec_o          = '0;
    dec_o.is_clear = (opcode_i == OP_CLEAR);
    dec_o.is_carve = (opcode_i == OP_CARVE);
    dec_o.dir_up   = (direction_i == DIR_UP) || (direction_i == DIR_DOWN);
    case (opcode_i)
      OP_CARVE: dec_o.bad = outside || (direction_i == DIR_DOWN) || (direction_i == DIR_LEFT);
      OP_QUERY: dec_o.bad = outside;
      OP_CLEAR: dec_o.bad = 1'b0;
      default:  dec_o.bad = 1'b1;
    endcase
    dec_o.border = ((direction_i == DIR_UP) && (cell_y_i == 5'd0)) ||
                   ((direction_i == DIR_RIGHT) && (x7 == w - 7'd1));
    case (direction_i)
      DIR_UP:    dec_o.closed = (cell_y_i == 5'd0);
      DIR_RIGHT: dec_o.closed = (x7 == w - 7'd1);
      DIR_DOWN:  dec_o.closed = (y7 == h - 7'd1);
      DIR_LEFT:  dec_o.closed = (cell_x_i == 5'd0);
      default:   dec_o.closed = 1'b1;
    endcase
  end

  // Cell addresses: first read, and carve neighbor
  always_comb begin
    rd_addr_o = cell_idx(int'(cell_x_i), int'(cell_y_i));
    if (opcode_i == OP_QUERY) begin
      case (direction_i)
        DIR_DOWN: rd_addr_o = cell_idx(int'(cell_x_i), int'(cell_y_i) + 1);
        DIR_LEFT: rd_addr_o = cell_idx(int'(cell_x_i) - 1, int'(cell_y_i));
        default:  rd_addr_o = cell_idx(int'(cell_x_i), int'(cell_y_i));
      endcase
    end
    if (direction_i == DIR_UP) begin
      nb_addr_o = cell_idx(int'(cell_x_i), int'(cell_y_i) - 1);
    end else begin
      nb_addr_o = cell_idx(int'(cell_x_i) + 1, int'(cell_y_i));
    end
  end

endmodule

// ===== rtl/maze_wall_carver_union.sv =====
// Top level: maze wall carver with set joining over one cell RAM.
//
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+------------------------
//  command  | opcode_i cell_x_i cell_y_i direction_i        | start_i & !busy_o
//  result   | passage_open_o status_o                      | done_o, one cycle
//  config   | cfg_idx_i cfg_wdata_i                        | cfg_we_i
//
// Rejected beats, border cases and queries through the border: result in the cycle after the beat.
// A successful carve runs the relabel sweep over the cell RAM, one entry per cycle.
// A clear command runs a clearing pass over every cell. After reset the same clearing
// pass runs (busy_o high, no result beat).
// The receiver cannot stall: each result beat stands for exactly one cycle.
module maze_wall_carver_union #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] opcode_i,
  input  logic [4:0] cell_x_i,
  input  logic [4:0] cell_y_i,
  input  logic [1:0] direction_i,
  output logic       done_o,
  output logic       passage_open_o,
  output logic [1:0] status_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_wdata_i
);

  import mwc_pkg::*;

  localparam int CellCount = MAX_WIDTH * MAX_HEIGHT;
  localparam int IdxW      = $clog2(CellCount);
  localparam int WordW     = IdxW + 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CellCount - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLEAR   = 3'd1;
  localparam logic [2:0] S_QUERY   = 3'd2;
  localparam logic [2:0] S_CARVE_C = 3'd3;
  localparam logic [2:0] S_CARVE_N = 3'd4;
  localparam logic [2:0] S_SWEEP   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            report_q, report_d;
  logic [IdxW-1:0] c_addr_q, c_addr_d, n_addr_q, n_addr_d;
  logic [IdxW-1:0] old_id_q, old_id_d, new_id_q, new_id_d;
  logic            dir_up_q, dir_up_d;
  logic [5:0]      width_q, height_q;
  logic            done_q, done_d;
  logic            open_q, open_d;
  status_e         status_q, status_d;

  dec_t            dec;
  logic [IdxW-1:0] rd_addr, nb_addr;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  logic             rd_up, rd_right;
  logic [IdxW-1:0]  rd_label;
  logic             hit_c;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 6'd16;
      height_q <= 6'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GRID_WIDTH) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_GRID_HEIGHT) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  mwc_decode #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_decode (
    .opcode_i      (opcode_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .direction_i   (direction_i),
    .grid_width_i  (width_q),
    .grid_height_i (height_q),
    .dec_o         (dec),
    .rd_addr_o     (rd_addr),
    .nb_addr_o     (nb_addr)
  );

  // Cell word: {up_open, right_open, set_label}
  mwc_ram #(
    .Width (WordW),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_up    = ram_rdata[WordW-1];
  assign rd_right = ram_rdata[WordW-2];
  assign rd_label = ram_rdata[IdxW-1:0];
  assign hit_c    = (cnt_q == c_addr_q);

  // Sequencer: read, compare, sweep, write back and clear
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    report_d  = report_q;
    c_addr_d  = c_addr_q;
    n_addr_d  = n_addr_q;
    old_id_d  = old_id_q;
    new_id_d  = new_id_q;
    dir_up_d  = dir_up_q;
    done_d    = 1'b0;
    open_d    = open_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = rd_addr;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (dec.is_clear) begin
            state_d  = S_CLEAR;
            cnt_d    = '0;
            report_d = 1'b1;
          end else if (dec.bad) begin
            done_d   = 1'b1;
            open_d   = 1'b0;
            status_d = StBad;
          end else if (dec.is_carve) begin
            if (dec.border) begin
              done_d   = 1'b1;
              open_d   = 1'b0;
              status_d = StBorder;
            end else begin
              state_d  = S_CARVE_C;
              c_addr_d = rd_addr;
              n_addr_d = nb_addr;
              dir_up_d = dec.dir_up;
            end
          end else if (dec.closed) begin
            done_d   = 1'b1;
            open_d   = 1'b0;
            status_d = StDone;
          end else begin
            state_d  = S_QUERY;
            dir_up_d = dec.dir_up;
          end
        end
      end
      S_QUERY: begin
        done_d   = 1'b1;
        open_d   = dir_up_q ? rd_up : rd_right;
        status_d = StDone;
        state_d  = S_IDLE;
      end
      S_CARVE_C: begin
        old_id_d  = rd_label;
        ram_raddr = n_addr_q;
        state_d   = S_CARVE_N;
      end
      S_CARVE_N: begin
        new_id_d = rd_label;
        if (rd_label == old_id_q) begin
          done_d   = 1'b1;
          open_d   = 1'b0;
          status_d = StJoined;
          state_d  = S_IDLE;
        end else begin
          ram_raddr = '0;
          cnt_d     = '0;
          state_d   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // rdata holds entry cnt_q; relabel members of the old set
        if (rd_label == old_id_q) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_up | (hit_c & dir_up_q), rd_right | (hit_c & ~dir_up_q), new_id_q};
        end
        if (cnt_q == LastIdx) begin
          done_d   = 1'b1;
          open_d   = 1'b1;
          status_d = StDone;
          state_d  = S_IDLE;
        end else begin
          cnt_d     = cnt_q + 1'b1;
          ram_raddr = cnt_q + 1'b1;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {2'b00, cnt_q};
        if (cnt_q == LastIdx) begin
          state_d = S_IDLE;
          if (report_q) begin
            done_d   = 1'b1;
            open_d   = 1'b0;
            status_d = StDone;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    c_addr_q <= c_addr_d;
    n_addr_q <= n_addr_d;
    old_id_q <= old_id_d;
    new_id_q <= new_id_d;
    dir_up_q <= dir_up_d;
    open_q   <= open_d;
    status_q <= status_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign passage_open_o = open_q;
  assign status_o       = status_q;

  // Checks
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted beat neither started work nor produced a result");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SWEEP) || (state_q == S_CLEAR))
    else $error("cell RAM written outside sweep or clear");

  a_sweep_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> old_id_q != new_id_q)
    else $error("relabel sweep running on identical set labels");

  a_refused_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != StDone) |-> !passage_open_o)
    else $error("refused beat reports an open passage");

  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP && cnt_q == LastIdx |=> done_o && passage_open_o && !busy_o)
    else $error("sweep end without carve result");

endmodule
